>>> sv/tcw_pkg.sv
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int ADDR_W = 11;
   localparam int CHAR_W = 8;
   localparam int CELL_W = 16;

   localparam logic [CHAR_W-1:0] ATTR_RESET     = 8'h0F;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'd32;

   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic clear_step;
      logic latch;
      logic exec;
      logic scroll_step;
      logic drain;
      logic blank_step;
   } cmd_type;

   typedef struct packed {
      logic scroll_needed;
      logic copy_end;
      logic scan_end;
   } status_type;

endpackage

>>> sv/tcw_datapath.sv
module tcw_datapath
   import tcw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              req_func,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [ADDR_W-1:0] req_cell_index,
   input  logic              csr_write,
   input  logic [CHAR_W-1:0] csr_data,
   output logic [CELL_W-1:0] rsp_cell_data,
   output logic [COL_W-1:0]  rsp_cursor_column,
   output logic [ROW_W-1:0]  rsp_cursor_row
);

   logic [CELL_W-1:0] mem [CELLS];

   logic              func_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic [CHAR_W-1:0] attr_ff, attr_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [CELL_W-1:0] rdata_ff;

   logic [ADDR_W-1:0] cur_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              wr_en;
   logic              is_put, is_nl, is_bs, is_print;
   logic              at_last_col, at_last_row, advance, in_range;
   logic [CELL_W-1:0] blank_cell;

   always_comb begin
      is_put      = (func_ff == FUNC_PUT);
      is_nl       = (char_ff == CHAR_NEWLINE);
      is_bs       = (char_ff == CHAR_BACKSPACE);
      is_print    = (char_ff >= CHAR_BLANK) && !char_ff[CHAR_W-1];
      at_last_col = (col_ff == COL_W'(COLUMNS - 1));
      at_last_row = (row_ff == ROW_W'(ROWS - 1));
      advance     = is_put && (is_nl || (is_print && at_last_col));
      in_range    = (idx_ff < ADDR_W'(CELLS));
      cur_addr    = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
      blank_cell  = {attr_ff, CHAR_BLANK};

      status.scroll_needed = advance && at_last_row;
      status.copy_end      = (scan_ff == ADDR_W'(CELLS - COLUMNS - 1));
      status.scan_end      = (scan_ff == ADDR_W'(CELLS - 1));

      attr_in = csr_write ? csr_data : attr_ff;

      col_in = col_ff;
      row_in = row_ff;
      if (cmd.exec && is_put) begin
         priority if (is_nl) begin
            col_in = '0;
         end else if (is_bs) begin
            if (col_ff != '0) col_in = col_ff - COL_W'(1);
         end else if (is_print) begin
            col_in = at_last_col ? '0 : col_ff + COL_W'(1);
         end else begin
            col_in = col_ff;
         end
         if (advance && !at_last_row) row_in = row_ff + ROW_W'(1);
      end

      priority if (cmd.clear_step || cmd.scroll_step || cmd.blank_step) begin
         scan_in = scan_ff + ADDR_W'(1);
      end else if (cmd.exec) begin
         scan_in = '0;
      end else if (cmd.drain) begin
         scan_in = ADDR_W'(CELLS - COLUMNS);
      end else begin
         scan_in = scan_ff;
      end

      pend_in      = cmd.scroll_step;
      pend_addr_in = scan_ff;

      if (cmd.scroll_step) begin
         rd_addr = scan_ff + ADDR_W'(COLUMNS);
      end else begin
         rd_addr = in_range ? idx_ff : '0;
      end

      wr_en   = 1'b0;
      wr_addr = cur_addr;
      wr_data = blank_cell;
      priority if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = scan_ff;
         wr_data = '0;
      end else if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = rdata_ff;
      end else if (cmd.blank_step) begin
         wr_en   = 1'b1;
         wr_addr = scan_ff;
      end else if (cmd.exec && is_put && is_print) begin
         wr_en   = 1'b1;
         wr_data = {attr_ff, char_ff};
      end else if (cmd.exec && is_put && is_bs && (col_ff != '0)) begin
         wr_en   = 1'b1;
         wr_addr = cur_addr - ADDR_W'(1);
      end else begin
         wr_en   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff <= req_func;
         char_ff <= req_char_code;
         idx_ff  <= req_cell_index;
      end
      pend_addr_ff <= pend_addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
         col_ff  <= '0;
         row_ff  <= '0;
         scan_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         attr_ff <= attr_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         scan_ff <= scan_in;
         pend_ff <= pend_in;
      end
   end

   assign rsp_cell_data     = ((func_ff == FUNC_READ) && in_range) ? rdata_ff : '0;
   assign rsp_cursor_column = col_ff;
   assign rsp_cursor_row    = row_ff;

endmodule

>>> sv/tcw_controller.sv
module tcw_controller
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_BLANK  = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.scan_end) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.scroll_needed ? S_SCROLL : S_RESP;
         end
         S_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (status.copy_end) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            cmd.drain = 1'b1;
            state_in  = S_BLANK;
         end
         S_BLANK: begin
            cmd.blank_step = 1'b1;
            if (status.scan_end) state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

>>> sv/text_console_character_writer.sv
// read, or put without scroll: strobe two cycles after the accepting edge,
// next word accepted three cycles after the previous one
// put that scrolls: one copy cycle per cell above the bottom row plus one
// cycle per bottom row cell, one read and one write a cycle on the screen
// store, about 2004 cycles
// reset: cursor to the top left, attribute 0x0f, then a 2000-cycle clearing pass
// over the screen store with busy high; results are strobed, never stalled
module text_console_character_writer
   import tcw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_func,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [ADDR_W-1:0] req_cell_index,
   output logic              rsp_valid,
   output logic [CELL_W-1:0] rsp_cell_data,
   output logic [COL_W-1:0]  rsp_cursor_column,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CHAR_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tcw_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tcw_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_func),
      .req_char_code     (req_char_code),
      .req_cell_index    (req_cell_index),
      .csr_write         (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .rsp_cell_data     (rsp_cell_data),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row)
   );

endmodule

>>> sv/tcw_checker.sv
module tcw_checker
   import tcw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              req_func,
   input logic              rsp_valid,
   input logic [COL_W-1:0]  rsp_cursor_column,
   input logic [ROW_W-1:0]  rsp_cursor_row
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after an accepted word");

   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_READ) |=> ##1 rsp_valid)
      else $error("read result not strobed on time");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_column < COL_W'(COLUMNS)) && (rsp_cursor_row < ROW_W'(ROWS)))
      else $error("cursor out of screen");

endmodule

bind text_console_character_writer tcw_checker u_checker (.*);
